// ===== src/ghf_pkg.sv =====
// Shared constants, codes and types of the 3x3 height grid hole filler.
package ghf_pkg;

    localparam int MAX_COLS_DEF    = 1024;
    localparam int HEIGHT_BITS_DEF = 24;

    // Frame geometry registers.
    localparam int COLS_CFG_W = 11;
    localparam int ROWS_W     = 13;
    localparam int ROW_W      = 12;
    localparam int ROW_CAP    = 4096;

    // Configuration port.
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;

    // Neighbour slots of the 3x3 window, centre excluded.
    localparam int NB_COUNT = 8;
    localparam int NB_UL = 0;
    localparam int NB_UP = 1;
    localparam int NB_UR = 2;
    localparam int NB_LF = 3;
    localparam int NB_RT = 4;
    localparam int NB_DL = 5;
    localparam int NB_DN = 6;
    localparam int NB_DR = 7;

    // Opposite pairs in priority order: vertical, main diagonal,
    // anti-diagonal, horizontal.
    localparam int PAIR_COUNT = 4;
    localparam int PAIR_A [PAIR_COUNT] = '{NB_DN, NB_DR, NB_DL, NB_RT};
    localparam int PAIR_B [PAIR_COUNT] = '{NB_UP, NB_UL, NB_UR, NB_LF};

    // Neighbour count width and quotient digits resolved per divider cycle.
    localparam int CNT_BITS   = 4;
    localparam int DIV_DIGITS = 8;

    // Control of one accepted word, captured at acceptance.
    typedef struct packed {
        logic is_job;   // word produces a result
        logic is_cell;  // word carries a grid cell to store
        logic has_up;
        logic has_low;
        logic has_lr;
        logic has_l;
        logic has_r;
        logic ctr_raw;  // centre comes from the measured line
        logic last;
    } job_ctl_t;

endpackage

// ===== src/ghf_fill.sv =====
// Two-stage pair search and neighbour summation for one missing cell.
module ghf_fill #(
    parameter int H = ghf_pkg::HEIGHT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic signed [H-1:0]                  nb_h [ghf_pkg::NB_COUNT],
    input  logic        [ghf_pkg::NB_COUNT-1:0]  nb_v,
    output logic                                 found,
    output logic signed [H-1:0]                  mean_h,
    output logic signed [H+2:0]                  nb_sum,
    output logic        [ghf_pkg::CNT_BITS-1:0]  nb_cnt
);

    logic        [ghf_pkg::PAIR_COUNT-1:0] both_next, both_reg;
    logic        [H:0]   diff_next [ghf_pkg::PAIR_COUNT];
    logic        [H:0]   diff_reg  [ghf_pkg::PAIR_COUNT];
    logic signed [H:0]   psum_next [ghf_pkg::PAIR_COUNT];
    logic signed [H:0]   psum_reg  [ghf_pkg::PAIR_COUNT];
    logic signed [H+1:0] term      [ghf_pkg::NB_COUNT];
    logic signed [H+1:0] half_a_next, half_a_reg, half_b_next, half_b_reg;
    logic [ghf_pkg::CNT_BITS-1:0] cnt_next, cnt_reg;

    logic                found_next;
    logic        [H:0]   best;
    logic signed [H:0]   sel_sum;
    logic signed [H:0]   rnd;
    logic signed [H:0]   halved;
    logic signed [H+2:0] sum_next;

    // First stage: pair differences and sums, masked partial sums.
    always_comb
    begin
        logic signed [H:0] a;
        logic signed [H:0] b;
        logic signed [H:0] d;
        for (int k = 0; k < ghf_pkg::PAIR_COUNT; k++)
        begin
            a = {nb_h[ghf_pkg::PAIR_A[k]][H-1], nb_h[ghf_pkg::PAIR_A[k]]};
            b = {nb_h[ghf_pkg::PAIR_B[k]][H-1], nb_h[ghf_pkg::PAIR_B[k]]};
            d = a - b;
            both_next[k] = nb_v[ghf_pkg::PAIR_A[k]] & nb_v[ghf_pkg::PAIR_B[k]];
            diff_next[k] = d[H] ? -d : d;
            psum_next[k] = a + b;
        end
        for (int i = 0; i < ghf_pkg::NB_COUNT; i++)
        begin
            term[i] = '0;
            if (nb_v[i])
            begin
                term[i] = {{2{nb_h[i][H-1]}}, nb_h[i]};
            end
        end
        half_a_next = term[0] + term[1] + term[2] + term[3];
        half_b_next = term[4] + term[5] + term[6] + term[7];
        cnt_next    = ghf_pkg::CNT_BITS'($countones(nb_v));
    end

    always_ff @(posedge clk)
    begin
        both_reg   <= both_next;
        diff_reg   <= diff_next;
        psum_reg   <= psum_next;
        half_a_reg <= half_a_next;
        half_b_reg <= half_b_next;
        cnt_reg    <= cnt_next;
    end

    // Second stage: strictly smaller difference wins, so earlier pairs win ties.
    always_comb
    begin
        found_next = 1'b0;
        best       = '0;
        sel_sum    = '0;
        for (int k = 0; k < ghf_pkg::PAIR_COUNT; k++)
        begin
            if (both_reg[k] && (!found_next || diff_reg[k] < best))
            begin
                found_next = 1'b1;
                best       = diff_reg[k];
                sel_sum    = psum_reg[k];
            end
        end
        rnd      = sel_sum + $signed({{H{1'b0}}, sel_sum[H]});
        halved   = rnd >>> 1;
        sum_next = {half_a_reg[H+1], half_a_reg} + {half_b_reg[H+1], half_b_reg};
    end

    always_ff @(posedge clk)
    begin
        found  <= found_next;
        mean_h <= halved[H-1:0];
        nb_sum <= sum_next;
        nb_cnt <= cnt_reg;
    end

endmodule

// ===== src/ghf_div.sv =====
// Signed divider by a small count, several quotient digits per cycle, truncating.
module ghf_div #(
    parameter int W = ghf_pkg::HEIGHT_BITS_DEF + 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [W-1:0]                 dividend,
    input  logic        [ghf_pkg::CNT_BITS-1:0] divisor,
    output logic                                done,
    output logic signed [W-1:0]                 quotient
);

    localparam int DIG = ghf_pkg::DIV_DIGITS;
    localparam int NC  = (W + DIG - 1) / DIG;
    localparam int PW  = NC * DIG;
    localparam int SW  = $clog2(NC + 1);
    localparam int CB  = ghf_pkg::CNT_BITS;

    logic          busy_reg, done_reg;
    logic [SW-1:0] step_reg;
    logic [PW-1:0] m_reg, m_next;
    logic [PW-1:0] q_reg, q_next;
    logic [CB-1:0] r_reg, r_next;
    logic [CB-1:0] d_reg;
    logic          neg_reg;
    logic [W-1:0]  du;
    logic [W-1:0]  mag;
    logic [PW-1:0] q_signed;

    assign du  = dividend;
    assign mag = du[W-1] ? (~du + W'(1)) : du;

    // One restoring step per quotient digit; the remainder stays below the divisor.
    always_comb
    begin
        m_next = m_reg;
        q_next = q_reg;
        r_next = r_reg;
        for (int i = 0; i < DIG; i++)
        begin
            r_next = {r_next[CB-2:0], m_next[PW-1]};
            m_next = m_next << 1;
            if (r_next >= d_reg)
            begin
                r_next = r_next - d_reg;
                q_next = {q_next[PW-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_next[PW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= SW'(NC);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - SW'(1);
                if (step_reg == SW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            m_reg   <= PW'(mag);
            q_reg   <= '0;
            r_reg   <= '0;
            d_reg   <= divisor;
            neg_reg <= du[W-1];
        end
        else if (busy_reg)
        begin
            m_reg <= m_next;
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign q_signed = neg_reg ? (~q_reg + PW'(1)) : q_reg;
    assign quotient = q_signed[W-1:0];
    assign done     = done_reg;

endmodule

// ===== src/grid_hole_fill_3x3.sv =====
// Top level of the streaming 3x3 hole filler for a raster of heights.
//
// Cells of a height grid arrive in row order, grid_cols per row and grid_rows per
// frame, each a signed Q.8 height with a measured flag. Every missing cell is
// filled from its eight neighbours: of the opposite pairs vertical, main
// diagonal, anti-diagonal and horizontal whose two cells are valid, the pair
// with the smallest absolute difference (earlier pair on a tie) gives its mean,
// truncated toward zero; without such a pair the cell takes the truncated mean
// of its valid neighbours, and with none it leaves as height 0, not valid.
// Neighbours above and to the left carry their filled values. Cell (r,c) comes
// out when cell (r+1,c+1) is taken, a last-column cell when cell (r+2,0) is;
// after the last cell of a frame, the owed results leave one per flush word
// (cmd = 1), and the final one has frame_end set. Cells sent while results are
// still owed and flushes with nothing owed are taken and dropped. Two line
// memories of MAX_COLS entries hold the last filled row and the last measured
// row; each has one read and one write port, so a word that stores a cell or
// produces a result first reads the left, centre, right and stored columns in
// turn; a result word then runs the pair search and the decision, and the
// divider when it needs the neighbour mean; every such word ends with
// write-back, and a dropped word is taken without leaving idle. A new result
// waits while the previous one is stalled in the output register. Writing
// grid_cols or grid_rows restarts the frame and drops owed results; write them
// only while the block is idle. There is no clearing pass after reset.
module grid_hole_fill_3x3 #(
    parameter int MAX_COLS    = ghf_pkg::MAX_COLS_DEF,
    parameter int HEIGHT_BITS = ghf_pkg::HEIGHT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ghf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ghf_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 cmd,
    input  logic signed [HEIGHT_BITS-1:0]        cell_height,
    input  logic                                 cell_valid,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic signed [HEIGHT_BITS-1:0]        out_height,
    output logic                                 out_valid,
    output logic                                 frame_end
);

    localparam int H     = HEIGHT_BITS;
    localparam int AW    = $clog2(MAX_COLS);
    localparam int CNT_W = $clog2(MAX_COLS + 2);
    localparam int RW    = ghf_pkg::ROW_W;
    localparam int RSW   = ghf_pkg::ROWS_W;
    localparam int CB    = ghf_pkg::CNT_BITS;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_FILL0 = 3'd2;
    localparam logic [2:0] ST_FILL1 = 3'd3;
    localparam logic [2:0] ST_DEC   = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_WB    = 3'd6;

    // Read steps: left, centre, right column, then the column being stored.
    localparam logic [2:0] RD_LEFT  = 3'd0;
    localparam logic [2:0] RD_MID   = 3'd1;
    localparam logic [2:0] RD_RIGHT = 3'd2;
    localparam logic [2:0] RD_STORE = 3'd3;
    localparam logic [2:0] RD_LAST  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] rd_step_reg;

    logic [ghf_pkg::COLS_CFG_W-1:0] grid_cols_reg;
    logic [RSW-1:0]                 grid_rows_reg;
    logic [CNT_W-1:0]               cols_eff;
    logic [RSW-1:0]                 rows_eff;

    logic [RW-1:0]    row_reg, row_next;
    logic [AW-1:0]    col_reg, col_next;
    logic [CNT_W-1:0] pend_reg, pend_next;

    ghf_pkg::job_ctl_t ctl_reg, ctl_next;
    logic [AW-1:0]     job_c_reg, job_c_next;
    logic [AW-1:0]     job_cw_reg, job_cw_next;
    logic [H:0]        x_reg;
    logic              accept;
    logic              go;

    // Line memories: bit H is the valid flag, the rest the height.
    logic [H:0] done_mem [MAX_COLS];
    logic [H:0] raw_mem  [MAX_COLS];
    logic [H:0] done_rd, raw_rd;
    logic       mem_rd_en;
    logic [AW-1:0] rd_addr;
    logic       done_we, raw_we;

    // Captured neighbourhood.
    logic [H:0] dm1_reg, d0_reg, dp1_reg, rm1_reg, r0_reg, rp1_reg, rc_reg;
    logic [H:0] win0_reg, win1_reg;
    logic [H:0] ctr;

    logic signed [H-1:0]            nb_h [ghf_pkg::NB_COUNT];
    logic [ghf_pkg::NB_COUNT-1:0]   nb_v;
    logic                           fill_found;
    logic signed [H-1:0]            fill_mean;
    logic signed [H+2:0]            fill_sum;
    logic [CB-1:0]                  fill_cnt;

    logic                div_start, div_done;
    logic signed [H+2:0] div_q;

    logic signed [H-1:0] res_h_reg;
    logic                res_v_reg;
    logic                res_valid_reg;
    logic                can_commit;

    // Effective geometry: zero acts as one, large values are capped.
    always_comb
    begin
        if (grid_cols_reg == '0)
        begin
            cols_eff = CNT_W'(1);
        end
        else if (32'(grid_cols_reg) > 32'(MAX_COLS))
        begin
            cols_eff = CNT_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = CNT_W'(grid_cols_reg);
        end
        if (grid_rows_reg == '0)
        begin
            rows_eff = RSW'(1);
        end
        else if (32'(grid_rows_reg) > 32'(ghf_pkg::ROW_CAP))
        begin
            rows_eff = RSW'(ghf_pkg::ROW_CAP);
        end
        else
        begin
            rows_eff = grid_rows_reg;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    // Decode an incoming word: what it produces, which column it finishes and
    // how the position counters move.
    always_comb
    begin
        logic [AW-1:0]    cur_c;
        logic [CNT_W-1:0] col_inc;
        logic [RSW-1:0]   row_ext;
        logic             first;
        row_next    = row_reg;
        col_next    = col_reg;
        pend_next   = pend_reg;
        ctl_next    = '0;
        job_c_next  = '0;
        job_cw_next = '0;
        go          = 1'b0;
        cur_c       = (CNT_W'(col_reg) >= cols_eff) ? '0 : col_reg;
        col_inc     = CNT_W'(cur_c) + CNT_W'(1);
        row_ext     = RSW'(row_reg);
        first       = 1'b0;
        if (cmd)
        begin
            if (pend_reg != '0)
            begin
                go              = 1'b1;
                ctl_next.is_job = 1'b1;
                first = (rows_eff >= RSW'(2)) && (pend_reg == cols_eff + CNT_W'(1));
                if (first)
                begin
                    job_c_next       = AW'(cols_eff - CNT_W'(1));
                    ctl_next.has_up  = (rows_eff >= RSW'(3));
                    ctl_next.has_low = 1'b1;
                end
                else
                begin
                    job_c_next       = (pend_reg == cols_eff) ? '0
                                                              : AW'(cols_eff - pend_reg);
                    ctl_next.has_up  = (rows_eff >= RSW'(2));
                    ctl_next.ctr_raw = 1'b1;
                end
                ctl_next.last = (pend_reg == CNT_W'(1));
                pend_next     = pend_reg - CNT_W'(1);
            end
        end
        else if (pend_reg == '0)
        begin
            go               = 1'b1;
            ctl_next.is_cell = 1'b1;
            job_cw_next      = cur_c;
            if (row_ext >= RSW'(1) && cur_c != '0)
            begin
                ctl_next.is_job  = 1'b1;
                job_c_next       = cur_c - AW'(1);
                ctl_next.has_up  = (row_ext >= RSW'(2));
                ctl_next.has_low = 1'b1;
                ctl_next.has_lr  = 1'b1;
            end
            else if (row_ext >= RSW'(2) && cur_c == '0)
            begin
                ctl_next.is_job  = 1'b1;
                job_c_next       = AW'(cols_eff - CNT_W'(1));
                ctl_next.has_up  = (row_ext >= RSW'(3));
                ctl_next.has_low = 1'b1;
            end
            if (col_inc >= cols_eff)
            begin
                col_next = '0;
                if (row_ext + RSW'(1) >= rows_eff)
                begin
                    row_next  = '0;
                    pend_next = cols_eff + ((rows_eff >= RSW'(2)) ? CNT_W'(1) : CNT_W'(0));
                end
                else
                begin
                    row_next = row_reg + RW'(1);
                end
            end
            else
            begin
                col_next = AW'(col_inc);
            end
        end
        ctl_next.has_l = (job_c_next != '0);
        ctl_next.has_r = (CNT_W'(job_c_next) + CNT_W'(1) < cols_eff);
    end

    // Read sequencing over both line memories.
    assign mem_rd_en = (state_reg == ST_READ) && (rd_step_reg != RD_LAST);

    always_comb
    begin
        unique case (rd_step_reg)
            RD_LEFT:  rd_addr = job_c_reg - AW'(1);
            RD_MID:   rd_addr = job_c_reg;
            RD_RIGHT: rd_addr = job_c_reg + AW'(1);
            default:  rd_addr = job_cw_reg;
        endcase
    end

    assign can_commit = !(ctl_reg.is_job && res_valid_reg && res_stall);
    assign done_we    = (state_reg == ST_WB) && can_commit && ctl_reg.is_job;
    assign raw_we     = (state_reg == ST_WB) && can_commit && ctl_reg.is_cell;

    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
        begin
            done_rd <= done_mem[rd_addr];
            raw_rd  <= raw_mem[rd_addr];
        end
        if (done_we)
        begin
            done_mem[job_c_reg] <= {res_v_reg, res_h_reg};
        end
        if (raw_we)
        begin
            raw_mem[job_cw_reg] <= x_reg;
        end
    end

    // Neighbourhood assembly; cells outside the grid or not yet seen are invalid.
    assign ctr = ctl_reg.ctr_raw ? r0_reg : win1_reg;

    always_comb
    begin
        nb_h[ghf_pkg::NB_UL] = win0_reg[H-1:0];
        nb_v[ghf_pkg::NB_UL] = ctl_reg.has_up & ctl_reg.has_l & win0_reg[H];
        nb_h[ghf_pkg::NB_UP] = d0_reg[H-1:0];
        nb_v[ghf_pkg::NB_UP] = ctl_reg.has_up & d0_reg[H];
        nb_h[ghf_pkg::NB_UR] = dp1_reg[H-1:0];
        nb_v[ghf_pkg::NB_UR] = ctl_reg.has_up & ctl_reg.has_r & dp1_reg[H];
        nb_h[ghf_pkg::NB_LF] = dm1_reg[H-1:0];
        nb_v[ghf_pkg::NB_LF] = ctl_reg.has_l & dm1_reg[H];
        nb_h[ghf_pkg::NB_RT] = rp1_reg[H-1:0];
        nb_v[ghf_pkg::NB_RT] = ctl_reg.has_r & rp1_reg[H];
        nb_h[ghf_pkg::NB_DL] = rm1_reg[H-1:0];
        nb_v[ghf_pkg::NB_DL] = ctl_reg.has_low & ctl_reg.has_l & rm1_reg[H];
        nb_h[ghf_pkg::NB_DN] = r0_reg[H-1:0];
        nb_v[ghf_pkg::NB_DN] = ctl_reg.has_low & r0_reg[H];
        nb_h[ghf_pkg::NB_DR] = x_reg[H-1:0];
        nb_v[ghf_pkg::NB_DR] = ctl_reg.has_low & ctl_reg.has_lr & x_reg[H];
    end

    ghf_fill #(
        .H (H)
    ) u_fill (
        .clk    (clk),
        .nb_h   (nb_h),
        .nb_v   (nb_v),
        .found  (fill_found),
        .mean_h (fill_mean),
        .nb_sum (fill_sum),
        .nb_cnt (fill_cnt)
    );

    assign div_start = (state_reg == ST_DEC) && !ctr[H] && !fill_found
                       && (fill_cnt != '0);

    ghf_div #(
        .W (H + 3)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (fill_sum),
        .divisor  (fill_cnt),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && go)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (rd_step_reg == RD_LAST)
                begin
                    state_next = ctl_reg.is_job ? ST_FILL0 : ST_WB;
                end
            end
            ST_FILL0: state_next = ST_FILL1;
            ST_FILL1: state_next = ST_DEC;
            ST_DEC:   state_next = div_start ? ST_DIV : ST_WB;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                if (can_commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_step_reg   <= RD_LEFT;
            grid_cols_reg <= ghf_pkg::COLS_CFG_W'(1024);
            grid_rows_reg <= RSW'(1024);
            row_reg       <= '0;
            col_reg       <= '0;
            pend_reg      <= '0;
            ctl_reg       <= '0;
            res_valid_reg <= 1'b0;
            win0_reg      <= '0;
            win1_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_READ)
            begin
                rd_step_reg <= (rd_step_reg == RD_LAST) ? RD_LEFT
                                                        : rd_step_reg + 3'd1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ghf_pkg::CFG_COLS: grid_cols_reg <= cfg_data[ghf_pkg::COLS_CFG_W-1:0];
                    ghf_pkg::CFG_ROWS: grid_rows_reg <= cfg_data[RSW-1:0];
                    default:           grid_rows_reg <= grid_rows_reg;
                endcase
                row_reg  <= '0;
                col_reg  <= '0;
                pend_reg <= '0;
            end
            else if (accept)
            begin
                row_reg  <= row_next;
                col_reg  <= col_next;
                pend_reg <= pend_next;
            end
            if (accept)
            begin
                ctl_reg <= ctl_next;
            end
            // A committed result refills the output register in the same cycle
            // that a draining one leaves it.
            if (done_we)
            begin
                res_valid_reg <= 1'b1;
                win0_reg      <= d0_reg;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            if (raw_we)
            begin
                win1_reg <= rc_reg;
            end
        end
    end

    // Data path registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_c_reg  <= job_c_next;
            job_cw_reg <= job_cw_next;
            x_reg      <= {cell_valid, cell_height};
        end
        if (state_reg == ST_READ)
        begin
            case (rd_step_reg)
                RD_MID:
                begin
                    dm1_reg <= done_rd;
                    rm1_reg <= raw_rd;
                end
                RD_RIGHT:
                begin
                    d0_reg <= done_rd;
                    r0_reg <= raw_rd;
                end
                RD_STORE:
                begin
                    dp1_reg <= done_rd;
                    rp1_reg <= raw_rd;
                end
                RD_LAST:  rc_reg <= raw_rd;
                default:  rc_reg <= rc_reg;
            endcase
        end
        if (state_reg == ST_DEC)
        begin
            if (ctr[H])
            begin
                res_h_reg <= ctr[H-1:0];
                res_v_reg <= 1'b1;
            end
            else if (fill_found)
            begin
                res_h_reg <= fill_mean;
                res_v_reg <= 1'b1;
            end
            else
            begin
                res_h_reg <= '0;
                res_v_reg <= 1'b0;
            end
        end
        else if (state_reg == ST_DIV && div_done)
        begin
            res_h_reg <= div_q[H-1:0];
            res_v_reg <= 1'b1;
        end
        if (done_we)
        begin
            out_height <= res_h_reg;
            out_valid  <= res_v_reg;
            frame_end  <= ctl_reg.last;
        end
    end

    assign res_valid = res_valid_reg;

    // The owed-result count never exceeds one row plus the held corner cell.
    assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W + 1)'(pend_reg) <= (CNT_W + 1)'(cols_eff) + (CNT_W + 1)'(1))
        else $error("owed result count beyond one row");

    // The column position stays inside the configured row.
    assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(col_reg) < cols_eff)
        else $error("column position outside the row");

    // Only a word that produces a result ever uses the divider.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ctl_reg.is_job)
        else $error("divider busy for a word without result");

    // A result is written back only into a free or draining output register and is then presented.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_we |=> res_valid_reg)
        else $error("committed result not presented");

endmodule
